// ===== rtl/amt_pkg.sv =====
// Shared constants and types for the adaptive mean threshold block.
// No dependencies; imported by the top level.
package amt_pkg;

    localparam int MAX_WINDOW = 15;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W   = $clog2(MAX_WIDTH);       // column index
    localparam int DIM_W   = 11;                      // frame width / height registers
    localparam int ROW_W   = DIM_W;                   // row counter, runs past the frame on flush
    localparam int TAP_W   = $clog2(MAX_WINDOW + 1);  // window side and tap index
    localparam int BANK_W  = $clog2(MAX_WINDOW);      // line bank index
    localparam int LEAD_W  = TAP_W + DIM_W;           // ticks of lead before first result
    localparam int GRP     = 5;                       // taps per adder group
    localparam int NGRP    = (MAX_WINDOW + GRP - 1) / GRP;
    localparam int CSUM_W  = 12;                      // column sum, 15 * 255 fits
    localparam int WSUM_W  = 16;                      // window sum, 225 * 255 fits
    localparam int NN_W    = 2 * TAP_W;
    localparam int LHS_W   = 10 + NN_W + 1;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_WINDOW = 2'd0;
    localparam cfg_index_t REG_OFFSET = 2'd1;
    localparam cfg_index_t REG_WIDTH  = 2'd2;
    localparam cfg_index_t REG_HEIGHT = 2'd3;

    localparam logic [TAP_W-1:0] RST_WINDOW = TAP_W'(3);
    localparam logic [8:0]       RST_OFFSET = 9'd0;
    localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);

    typedef logic [MAX_WINDOW-1:0] tap_mask_t;

endpackage

// ===== rtl/adaptive_mean_threshold_top.sv =====
// Pipeline: the tick completing a window enters stage 0 at the edge that accepts it,
// then passes stages 1 to 3 and the output register; results lag input by a*W + a
// accepted ticks (a = window ahead span, W = width).
// Throughput: one word per cycle; the pipeline stalls only on m_tready.
// Reset (rst_n, async): registers to defaults, counters cleared; line banks not cleared.
// Depends on amt_pkg.
module adaptive_mean_threshold_top
    import amt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] pixel
    input  logic             s_tuser,   // [0] action (1 = padding tick)
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [0] white, [7:1] zero
    output logic             m_tlast,   // end_of_frame
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  cfg_index_t       cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    // configuration
    logic [TAP_W-1:0] win_reg;
    logic [8:0]       offset_reg;
    logic [DIM_W-1:0] fw_reg, fh_reg;
    logic             cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= RST_WINDOW;
            offset_reg <= RST_OFFSET;
            fw_reg     <= RST_WIDTH;
            fh_reg     <= RST_HEIGHT;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_WINDOW: win_reg    <= cfg_data[TAP_W-1:0];
                REG_OFFSET: offset_reg <= cfg_data[8:0];
                REG_WIDTH:  fw_reg     <= cfg_data;
                REG_HEIGHT: fh_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [TAP_W-1:0] n_c, half_c, ahead_c;
    logic [DIM_W-1:0] w_c, h_c;
    logic [LEAD_W-1:0] delay_c;
    logic [NN_W-1:0]  nn_c;

    always_comb
    begin
        n_c = (win_reg == '0) ? TAP_W'(1) :
              ((win_reg > TAP_W'(MAX_WINDOW)) ? TAP_W'(MAX_WINDOW) : win_reg);
        w_c = (fw_reg == '0) ? DIM_W'(1) :
              ((fw_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fw_reg);
        h_c = (fh_reg == '0) ? DIM_W'(1) :
              ((fh_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fh_reg);
        half_c  = n_c >> 1;
        ahead_c = n_c - TAP_W'(1) - half_c;
        delay_c = LEAD_W'(ahead_c) * LEAD_W'(w_c) + LEAD_W'(ahead_c);
        nn_c    = NN_W'(n_c) * NN_W'(n_c);
    end

    // pipeline enable: everything moves when the output slot is free
    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // input side counters
    logic [COL_W-1:0]  vcol_reg, vcol_next, ocol_reg, ocol_next;
    logic [ROW_W-1:0]  vrow_reg, vrow_next, orow_reg, orow_next;
    logic [BANK_W-1:0] ring_reg, ring_next;
    logic [LEAD_W-1:0] lead_reg, lead_next;
    logic in_frame, stall_tick, tick, wr_en, produce, last;

    always_comb
    begin
        in_frame   = vrow_reg < h_c;
        stall_tick = s_tuser && in_frame;
        tick       = s_tvalid && s_tready && !stall_tick;
        wr_en      = tick && in_frame;
        produce    = lead_reg >= delay_c;
        last       = produce && (orow_reg == h_c - DIM_W'(1))
                     && (DIM_W'(ocol_reg) == w_c - DIM_W'(1));

        vcol_next = vcol_reg;
        vrow_next = vrow_reg;
        ring_next = ring_reg;
        lead_next = lead_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (cfg_wr || (tick && last))
        begin
            vcol_next = '0;
            vrow_next = '0;
            ring_next = '0;
            lead_next = '0;
            ocol_next = '0;
            orow_next = '0;
        end
        else if (tick)
        begin
            if (DIM_W'(vcol_reg) + DIM_W'(1) >= w_c)
            begin
                vcol_next = '0;
                vrow_next = vrow_reg + ROW_W'(1);
                ring_next = (ring_reg == BANK_W'(MAX_WINDOW - 1)) ? '0
                            : ring_reg + BANK_W'(1);
            end
            else
                vcol_next = vcol_reg + COL_W'(1);
            if (!produce)
                lead_next = lead_reg + LEAD_W'(1);
            else if (DIM_W'(ocol_reg) + DIM_W'(1) >= w_c)
            begin
                ocol_next = '0;
                orow_next = orow_reg + ROW_W'(1);
            end
            else
                ocol_next = ocol_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcol_reg <= '0;
            vrow_reg <= '0;
            ring_reg <= '0;
            lead_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end
        else
        begin
            vcol_reg <= vcol_next;
            vrow_reg <= vrow_next;
            ring_reg <= ring_next;
            lead_reg <= lead_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
        end
    end

    // row and column masks for this tick
    tap_mask_t vmask, hmask;
    logic [DIM_W:0] hpos;

    always_comb
    begin
        hpos = (DIM_W+1)'(ocol_reg) + (DIM_W+1)'(ahead_c);
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            vmask[k] = (TAP_W'(k) < n_c) && (vrow_reg >= ROW_W'(k))
                       && ((vrow_reg - ROW_W'(k)) < h_c);
            hmask[k] = (TAP_W'(k) < n_c) && ((DIM_W+1)'(k) <= hpos)
                       && ((hpos - (DIM_W+1)'(k)) < (DIM_W+1)'(w_c));
        end
    end

    // line banks: one row each, bank = row mod MAX_WINDOW
    logic [7:0] rd_reg [MAX_WINDOW];

    for (genvar b = 0; b < MAX_WINDOW; b++)
    begin : g_bank
        logic [7:0] mem [MAX_WIDTH];
        always_ff @(posedge clk)
        begin
            if (wr_en && ring_reg == BANK_W'(b))
                mem[vcol_reg] <= s_tdata;
            if (en)
                rd_reg[b] <= mem[vcol_reg];
        end
    end

    // stage 0 registers
    logic              p0_valid_reg, p0_produce_reg, p0_last_reg;
    tap_mask_t         p0_vmask_reg, p0_hmask_reg;
    logic [BANK_W-1:0] p0_ring_reg;
    logic [7:0]        p0_pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_valid_reg <= 1'b0;
        else if (en)
            p0_valid_reg <= tick;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_produce_reg <= produce;
            p0_last_reg    <= last;
            p0_vmask_reg   <= vmask;
            p0_hmask_reg   <= hmask;
            p0_ring_reg    <= ring_reg;
            p0_pixel_reg   <= s_tdata;
        end
    end

    // stage 1: pick the column taps, partial column sums
    logic [7:0]        tap_raw [MAX_WINDOW];
    logic [CSUM_W-1:0] vgrp [NGRP];
    logic [BANK_W-1:0] bank_sel;

    always_comb
    begin
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            bank_sel = (p0_ring_reg >= BANK_W'(k)) ? p0_ring_reg - BANK_W'(k)
                       : BANK_W'(p0_ring_reg + BANK_W'(MAX_WINDOW) - BANK_W'(k));
            tap_raw[k] = (k == 0) ? p0_pixel_reg : rd_reg[bank_sel];
        end
        for (int g = 0; g < NGRP; g++)
        begin
            vgrp[g] = '0;
            for (int i = 0; i < GRP; i++)
                if (g * GRP + i < MAX_WINDOW)
                    if (p0_vmask_reg[g*GRP+i])
                        vgrp[g] = vgrp[g] + CSUM_W'(tap_raw[g*GRP+i]);
        end
    end

    logic              p1_valid_reg, p1_produce_reg, p1_last_reg;
    tap_mask_t         p1_hmask_reg;
    logic [CSUM_W-1:0] p1_grp_reg [NGRP];
    logic [7:0]        p1_center_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= p0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_produce_reg <= p0_produce_reg;
            p1_last_reg    <= p0_last_reg;
            p1_hmask_reg   <= p0_hmask_reg;
            p1_grp_reg     <= vgrp;
            p1_center_reg  <= tap_raw[ahead_c];
        end
    end

    // stage 2: column sum into the horizontal tap line
    logic [CSUM_W-1:0] colsum;
    logic [CSUM_W-1:0] hs_reg [MAX_WINDOW];
    logic [7:0]        cs_reg [MAX_WINDOW];

    always_comb
    begin
        colsum = '0;
        for (int g = 0; g < NGRP; g++)
            colsum = colsum + p1_grp_reg[g];
    end

    always_ff @(posedge clk)
    begin
        if (en && p1_valid_reg)
        begin
            hs_reg[0] <= colsum;
            cs_reg[0] <= p1_center_reg;
            for (int j = 1; j < MAX_WINDOW; j++)
            begin
                hs_reg[j] <= hs_reg[j-1];
                cs_reg[j] <= cs_reg[j-1];
            end
        end
    end

    logic      p2_valid_reg, p2_produce_reg, p2_last_reg;
    tap_mask_t p2_hmask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_produce_reg <= p1_produce_reg;
            p2_last_reg    <= p1_last_reg;
            p2_hmask_reg   <= p1_hmask_reg;
        end
    end

    // stage 3: partial window sums, scaled threshold side
    logic [WSUM_W-1:0]       hgrp [NGRP];
    logic signed [9:0]       adj;
    logic signed [LHS_W-1:0] lhs;

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            hgrp[g] = '0;
            for (int i = 0; i < GRP; i++)
                if (g * GRP + i < MAX_WINDOW)
                    if (p2_hmask_reg[g*GRP+i])
                        hgrp[g] = hgrp[g] + WSUM_W'(hs_reg[g*GRP+i]);
        end
        adj = $signed({2'b00, cs_reg[ahead_c]}) + $signed({offset_reg[8], offset_reg});
        lhs = LHS_W'(adj) * LHS_W'($signed({1'b0, nn_c}));
    end

    logic                    p3_valid_reg, p3_produce_reg, p3_last_reg;
    logic [WSUM_W-1:0]       p3_grp_reg [NGRP];
    logic signed [LHS_W-1:0] p3_lhs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (en)
            p3_valid_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_produce_reg <= p2_produce_reg;
            p3_last_reg    <= p2_last_reg;
            p3_grp_reg     <= hgrp;
            p3_lhs_reg     <= lhs;
        end
    end

    // stage 4: final sum and compare into the output register
    logic [WSUM_W-1:0] wsum;
    logic              white;

    always_comb
    begin
        wsum = '0;
        for (int g = 0; g < NGRP; g++)
            wsum = wsum + p3_grp_reg[g];
        white = p3_lhs_reg > $signed(LHS_W'(wsum));
    end

    logic white_reg, eof_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= p3_valid_reg && p3_produce_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            white_reg <= white;
            eof_reg   <= p3_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, white_reg};
    assign m_tlast  = eof_reg;

endmodule

// ===== rtl/amt_checker.sv =====
// Port-level checks for the adaptive mean threshold top level.
// Depends on amt_pkg; bound to adaptive_mean_threshold_top below.
module amt_checker
    import amt_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [7:0]       s_tdata,
    input logic             s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [7:0]       m_tdata,
    input logic             m_tlast,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input cfg_index_t       cfg_index,
    input logic [DIM_W-1:0] cfg_data
);

    // input side opens exactly when the output word is free or leaving
    a_ready_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output slot");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // only bit 0 of the output word carries data
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:1] == 7'b0)
        else $error("output pad bits not zero");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready low");

endmodule

bind adaptive_mean_threshold_top amt_checker u_amt_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for adaptive_mean_threshold_top: random frames and configs,
// exact integer prediction of each binary pixel result. Depends on amt_pkg and the RTL.
module tb_top;
    import amt_pkg::*;

    typedef struct {
        bit       pad;
        bit [7:0] px;
        int       gap;
    } pix_word_t;

    typedef struct {
        bit white;
        bit eof;
    } bin_word_t;

    localparam int RING_LEN = MAX_WINDOW * (MAX_WIDTH + 1);
    localparam int SETTLE   = 40;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;
    logic             m_tlast;
    logic             cfg_valid;
    logic             cfg_ready;
    cfg_index_t       cfg_index;
    logic [DIM_W-1:0] cfg_data;

    adaptive_mean_threshold_top uut (.*);

    // mirror of the block state
    bit [7:0]  ring [RING_LEN];
    bit [3:0]  win_reg;
    bit [8:0]  off_reg;
    bit [10:0] wid_reg;
    bit [10:0] hgt_reg;
    int        in_col, in_row, out_col, out_row, lead;

    pix_word_t pend_q[$];
    bin_word_t thr_q[$];
    int        errors;
    int        sent;
    bit        idle_en;
    int        hold_left;
    int        snd_wait, rcv_wait, rcv_gap;
    bit        in_fire;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int clampv(int v, int hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    task automatic restart_frame();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; lead = 0;
    endtask

    // Advance the mirror by one accepted word; queue a result if one is due.
    task automatic predict_threshold(input bit pad, input bit [7:0] px);
        int n, w, h, half, ahead, dly, sum, lhs, off, rr, cc;
        bin_word_t res;
        n = clampv(win_reg, MAX_WINDOW);
        w = clampv(wid_reg, MAX_WIDTH);
        h = clampv(hgt_reg, MAX_HEIGHT);
        half = n / 2;
        ahead = n - 1 - half;
        dly = ahead * w + ahead;
        off = $signed(off_reg);
        sum = 0;
        if (in_row < h)
        begin
            if (pad)
                return;
            ring[(in_row * w + in_col) % RING_LEN] = px;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
        end
        if (lead < dly)
        begin
            lead++;
            return;
        end
        for (int dy = -half; dy <= ahead; dy++)
        begin
            rr = out_row + dy;
            if (rr < 0 || rr >= h)
                continue;
            for (int dx = -half; dx <= ahead; dx++)
            begin
                cc = out_col + dx;
                if (cc >= 0 && cc < w)
                    sum += ring[(rr * w + cc) % RING_LEN];
            end
        end
        lhs = (int'(ring[(out_row * w + out_col) % RING_LEN]) + off) * n * n;
        res.white = lhs > sum;
        res.eof = (out_row == h - 1) && (out_col == w - 1);
        thr_q.push_back(res);
        if (res.eof)
            restart_frame();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    // Result check first: no result can come from the word accepted at this edge.
    always @(posedge clk)
    begin
        bin_word_t exp_w;
        in_fire <= s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (thr_q.size() == 0)
            begin
                $display("%0t: unexpected word white=%0b eof=%0b", $time, m_tdata[0], m_tlast);
                errors++;
            end
            else
            begin
                exp_w = thr_q.pop_front();
                if (m_tdata !== {7'd0, exp_w.white})
                begin
                    $display("%0t: tdata exp %02h got %02h", $time, {7'd0, exp_w.white}, m_tdata);
                    errors++;
                end
                if (m_tlast !== exp_w.eof)
                begin
                    $display("%0t: tlast exp %0b got %0b", $time, exp_w.eof, m_tlast);
                    errors++;
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
            predict_threshold(s_tuser, s_tdata);
    end

    // sender
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_fire))
        begin
            if (pend_q.size() == 0)
                s_tvalid <= 1'b0;
            else if (snd_wait < pend_q[0].gap)
            begin
                snd_wait++;
                s_tvalid <= 1'b0;
            end
            else
            begin
                snd_wait = 0;
                s_tuser  <= pend_q[0].pad;
                s_tdata  <= pend_q[0].px;
                s_tvalid <= 1'b1;
                void'(pend_q.pop_front());
                sent++;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                rcv_gap = idle_en ? $urandom_range(0, 17) : 0;
                rcv_wait = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rcv_wait < rcv_gap)
            begin
                rcv_wait++;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic int draw_gap();
        if (!idle_en || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    task automatic push_word(input bit pad, input bit [7:0] px);
        pix_word_t it;
        it.pad = pad;
        it.px = px;
        it.gap = draw_gap();
        pend_q.push_back(it);
    endtask

    task automatic wait_idle();
        while (pend_q.size() != 0 || s_tvalid || thr_q.size() != 0 || hold_left != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_WINDOW: win_reg = val[3:0];
            REG_OFFSET: off_reg = val[8:0];
            REG_WIDTH:  wid_reg = val;
            default:    hgt_reg = val;
        endcase
        restart_frame();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic bit [7:0] draw_pixel(int style);
        case (style)
            0: return 8'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'hff : 8'h00;
            default: return 8'd100 + 8'($urandom_range(0, 3));
        endcase
    endfunction

    // One frame plus exactly enough flush ticks; noise pads stall mid-frame.
    task automatic run_frame(input int wr, input int hr, input int nr, input int offv,
                             input bit noisy);
        int w, h, n, ahead, style;
        write_reg(REG_WINDOW, DIM_W'(nr));
        write_reg(REG_OFFSET, DIM_W'(offv & 'h1ff));
        write_reg(REG_WIDTH, DIM_W'(wr));
        write_reg(REG_HEIGHT, DIM_W'(hr));
        w = clampv(wr, MAX_WIDTH);
        h = clampv(hr, MAX_HEIGHT);
        n = clampv(nr, MAX_WINDOW);
        ahead = n - 1 - n / 2;
        style = $urandom_range(0, 2);
        for (int i = 0; i < w * h; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                push_word(1'b1, 8'($urandom_range(0, 255)));
            push_word(1'b0, draw_pixel(style));
        end
        for (int i = 0; i < ahead * w + ahead; i++)
            push_word($urandom_range(0, 3) != 0, 8'($urandom_range(0, 255)));
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0; cfg_index = REG_WINDOW; cfg_data = '0;
        errors = 0; sent = 0; idle_en = 1'b0; hold_left = 0;
        snd_wait = 0; rcv_wait = 0; rcv_gap = 0; in_fire = 1'b0;
        win_reg = RST_WINDOW; off_reg = RST_OFFSET; wid_reg = RST_WIDTH; hgt_reg = RST_HEIGHT;
        restart_frame();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, clamps, stalling pads, pixels during flush
        run_frame(4, 3, 3, 0, 1'b1);
        run_frame(1, 1, 15, -255, 1'b0);
        run_frame(2, 2, 0, 255, 1'b1);
        run_frame(3, 0, 2, 1, 1'b0);
        run_frame(0, 1, 1, -1, 1'b0);
        run_frame(40, 2, 15, 7, 1'b0);
        run_frame(1, 20, 15, -3, 1'b0);

        // receiver stalls long while sender streams, input must back up
        hold_left = 400;
        run_frame(12, 10, 5, 0, 1'b0);

        while (sent < 1300)
        begin
            idle_en = $urandom_range(0, 3) != 0;
            run_frame($urandom_range(1, 24), $urandom_range(1, 12), $urandom_range(0, 15),
                      $signed(9'($urandom)), $urandom_range(0, 1));
        end
        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
